/* rtl/v3n_pkg.sv */
// shared types and widths for the vector normalizer
// no dependencies
`default_nettype none
package v3n_pkg;

    localparam int IN_W   = 24;
    localparam int OUT_W  = 18;
    localparam int SUM_W  = 2 * IN_W;
    localparam int ROOT_W = IN_W;
    localparam int SREM_W = ROOT_W + 1;
    localparam int DREM_W = IN_W + 1;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][IN_W-1:0]  mag;
    } v3n_vec_t;

endpackage
`default_nettype wire

/* rtl/v3n_sqrt_cell.sv */
// one root bit of the digit-by-digit integer square root
// depends on v3n_pkg
`default_nettype none
module v3n_sqrt_cell
    import v3n_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SUM_W-1:0]  in_n,
    input  wire logic [SREM_W-1:0] in_rem,
    input  wire logic [ROOT_W-1:0] in_root,
    input  wire v3n_vec_t          in_vec,
    output logic                   out_valid,
    output logic [SUM_W-1:0]       out_n,
    output logic [SREM_W-1:0]      out_rem,
    output logic [ROOT_W-1:0]      out_root,
    output v3n_vec_t               out_vec
);

    logic              valid_reg;
    logic [SUM_W-1:0]  n_reg, n_next;
    logic [SREM_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    v3n_vec_t          vec_reg;

    logic [SREM_W+1:0] rem_sh;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;
    logic              take;

    always_comb
    begin
        rem_sh    = {in_rem, in_n[SUM_W-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        take      = (rem_sh >= trial);
        diff      = rem_sh - trial;
        rem_next  = take ? diff[SREM_W-1:0] : rem_sh[SREM_W-1:0];
        root_next = {in_root[ROOT_W-2:0], take};
        n_next    = {in_n[SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            vec_reg  <= in_vec;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_vec   = vec_reg;

endmodule
`default_nettype wire

/* rtl/v3n_div_cell.sv */
// one quotient bit of three restoring divisions by the shared length
// depends on v3n_pkg
`default_nettype none
module v3n_div_cell
    import v3n_pkg::*;
#(
    parameter int QW = 17
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [ROOT_W-1:0]            in_len,
    input  wire logic [2:0][DREM_W-1:0]       in_rem,
    input  wire logic [2:0][QW-1:0]           in_q,
    input  wire logic [2:0]                   in_neg,
    output logic                              out_valid,
    output logic [ROOT_W-1:0]                 out_len,
    output logic [2:0][DREM_W-1:0]            out_rem,
    output logic [2:0][QW-1:0]                out_q,
    output logic [2:0]                        out_neg
);

    logic                      valid_reg;
    logic [ROOT_W-1:0]         len_reg;
    logic [2:0][DREM_W-1:0]    rem_reg, rem_next;
    logic [2:0][QW-1:0]        q_reg, q_next;
    logic [2:0]                neg_reg;

    always_comb
    begin
        logic [DREM_W-1:0] r;
        logic              ge;
        for (int i = 0; i < 3; i++)
        begin
            ge          = (in_rem[i] >= {1'b0, in_len});
            r           = ge ? in_rem[i] - {1'b0, in_len} : in_rem[i];
            rem_next[i] = {r[DREM_W-2:0], 1'b0};
            q_next[i]   = {in_q[i][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= in_len;
            rem_reg <= rem_next;
            q_reg   <= q_next;
            neg_reg <= in_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_len   = len_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_neg   = neg_reg;

endmodule
`default_nettype wire

/* rtl/vector3_normalize.sv */
// vector3_normalize: 3d vector to unit vector in signed q1.FRAC_BITS
// depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell
//
// channel  dir  handshake                      content
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata x,y,z (24 bits each)
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata x,y,z (18 bits each), tuser zero_vec_err
// cfg      in   cfg_valid/cfg_ready            zero_raises_error
//
// one vector accepted per cycle while m_axis is not stalled; the path runs through stage a,
// stage b, the 24 square-root cells, the FRAC_BITS+1 divider cells and the output register.
// reset clears valid bits and the error mode; payload is not reset.
// a stall on m_axis freezes the whole chain and drops s_axis_tready.
`default_nettype none
module vector3_normalize
    import v3n_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // in_x, in_y, in_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // out_x, out_y, out_z, zero pad
    output logic             m_axis_tuser,   // zero_vec_err
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data        // zero_raises_error
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NS = ROOT_W;

    logic en;
    logic zre_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zre_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            zre_reg <= cfg_data;
        end
    end

    // stage a: magnitudes and squares
    logic                      a_valid_reg;
    v3n_vec_t                  a_vec_reg;
    logic [2:0][SUM_W-2:0]     a_sq_reg;
    v3n_vec_t                  a_vec_next;

    always_comb
    begin
        logic [IN_W-1:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c                   = s_axis_tdata[i*IN_W +: IN_W];
            a_vec_next.neg[i]   = c[IN_W-1];
            a_vec_next.mag[i]   = c[IN_W-1] ? (~c + 1'b1) : c;
        end
    end

    // stage b: sum of squares
    logic                 b_valid_reg;
    v3n_vec_t             b_vec_reg;
    logic [SUM_W-1:0]     b_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_vec_reg <= a_vec_next;
            for (int i = 0; i < 3; i++)
            begin
                a_sq_reg[i] <= {{(SUM_W-1-IN_W){1'b0}}, a_vec_next.mag[i]}
                               * a_vec_next.mag[i];
            end
            b_vec_reg <= a_vec_reg;
            b_sum_reg <= {1'b0, a_sq_reg[0]} + {1'b0, a_sq_reg[1]} + {1'b0, a_sq_reg[2]};
        end
    end

    // square root chain
    logic [NS:0]                   s_valid;
    logic [NS:0][SUM_W-1:0]        s_n;
    logic [NS:0][SREM_W-1:0]       s_rem;
    logic [NS:0][ROOT_W-1:0]       s_root;
    v3n_vec_t [NS:0]               s_vec;

    assign s_valid[0] = b_valid_reg;
    assign s_n[0]     = b_sum_reg;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_vec[0]   = b_vec_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        v3n_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s_valid[k]),
            .in_n      (s_n[k]),
            .in_rem    (s_rem[k]),
            .in_root   (s_root[k]),
            .in_vec    (s_vec[k]),
            .out_valid (s_valid[k+1]),
            .out_n     (s_n[k+1]),
            .out_rem   (s_rem[k+1]),
            .out_root  (s_root[k+1]),
            .out_vec   (s_vec[k+1])
        );
    end

    // divider chain
    logic [QW:0]                   d_valid;
    logic [QW:0][ROOT_W-1:0]       d_len;
    logic [QW:0][2:0][DREM_W-1:0]  d_rem;
    logic [QW:0][2:0][QW-1:0]      d_q;
    logic [QW:0][2:0]              d_neg;

    assign d_valid[0] = s_valid[NS];
    assign d_len[0]   = s_root[NS];
    assign d_q[0]     = '0;
    assign d_neg[0]   = s_vec[NS].neg;

    for (genvar i = 0; i < 3; i++)
    begin : g_rem0
        assign d_rem[0][i] = {1'b0, s_vec[NS].mag[i]};
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        v3n_div_cell #(.QW(QW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d_valid[k]),
            .in_len    (d_len[k]),
            .in_rem    (d_rem[k]),
            .in_q      (d_q[k]),
            .in_neg    (d_neg[k]),
            .out_valid (d_valid[k+1]),
            .out_len   (d_len[k+1]),
            .out_rem   (d_rem[k+1]),
            .out_q     (d_q[k+1]),
            .out_neg   (d_neg[k+1])
        );
    end

    // output register: sign restore and zero-vector handling
    logic                   o_valid_reg;
    logic [2:0][OUT_W-1:0]  o_data_reg, o_data_next;
    logic                   o_err_reg, o_err_next;
    logic                   len_zero;

    assign en = !o_valid_reg || m_axis_tready;

    always_comb
    begin
        logic [31:0] qe;
        len_zero = (d_len[QW] == '0);
        for (int i = 0; i < 3; i++)
        begin
            qe = 32'(d_q[QW][i]);
            qe = d_neg[QW][i] ? (~qe + 32'd1) : qe;
            o_data_next[i] = len_zero ? '0 : qe[OUT_W-1:0];
        end
        o_err_next = len_zero && zre_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= d_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_data_reg <= o_data_next;
            o_err_reg  <= o_err_next;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {2'b00, o_data_reg};
    assign m_axis_tuser  = o_err_reg;

endmodule
`default_nettype wire
